// ----- rtl/core/hbp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_pkg
// Shared types and constants for the huffman bit packer.
// ----------------------------------------------------------------------------
package hbp_pkg;

    // default sizes
    localparam int MAX_CODE_LEN_DEF = 16;
    localparam int SYMBOLS_DEF      = 256;

    // width of one stored code word
    localparam int CODE_BITS = 16;

    // bit position of the first bit in a byte
    localparam logic [2:0] TOP_BIT = 3'd7;

    // command codes
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    // input beat
    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  symbol;
        logic [15:0] code_word;
        logic [4:0]  code_length;
    } hbp_in_t;

    // output beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } hbp_out_t;

    // controller to datapath
    typedef struct packed {
        logic mem_write;
        logic mem_read;
        logic pack;
        logic flush;
        logic out_sel;
    } hbp_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic       sym_in_range;
        logic       pending_valid;
        logic [1:0] byte_count;
    } hbp_status_t;

endpackage

// ----- rtl/core/hbp_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_datapath
// Code and length tables, pending byte state and the byte packing logic.
// ----------------------------------------------------------------------------
module hbp_datapath #(
    parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOLS      = hbp_pkg::SYMBOLS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hbp_pkg::hbp_in_t    in_item,
    input  hbp_pkg::hbp_ctrl_t  ctrl,
    output hbp_pkg::hbp_status_t status,
    output logic [7:0]          out_byte
);
    import hbp_pkg::*;

    localparam int IDX_W = $clog2(SYMBOLS);
    localparam int CAP   = (MAX_CODE_LEN < CODE_BITS) ? MAX_CODE_LEN : CODE_BITS;
    localparam logic [4:0] CAP_LEN   = 5'(CAP);
    localparam logic [8:0] SYM_LIMIT = 9'(SYMBOLS);

    // tables
    logic [15:0]        code_mem [SYMBOLS];
    logic [4:0]         len_mem  [SYMBOLS];
    logic [SYMBOLS-1:0] len_valid_reg;

    logic [IDX_W-1:0] addr;
    logic [4:0]       load_len;

    // lookup results
    logic [15:0] code_rd_reg;
    logic [4:0]  len_rd_reg;
    logic        len_ok_reg;

    // pending byte state
    logic [7:0] pending_byte_reg, pending_byte_next;
    logic [2:0] bit_pos_reg, bit_pos_next;
    logic       pending_valid_reg, pending_valid_next;

    // result bytes
    logic [7:0] byte0_reg;
    logic [7:0] byte1_reg;

    // packing signals
    logic [4:0]  len_eff;
    logic [16:0] mask_wide;
    logic [15:0] code_masked;
    logic [15:0] code_rev;
    logic [2:0]  used_bits;
    logic [23:0] acc;
    logic [4:0]  total;

    assign addr     = in_item.symbol[IDX_W-1:0];
    assign load_len = (in_item.code_length > CAP_LEN) ? CAP_LEN : in_item.code_length;

    // range check, pending flag and byte count for the sequencer
    assign status = {({1'b0, in_item.symbol} < SYM_LIMIT), pending_valid_reg, total[4:3]};

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.mem_write)
        begin
            code_mem[addr] <= in_item.code_word;
            len_mem[addr]  <= load_len;
        end
        if (ctrl.mem_read)
        begin
            code_rd_reg <= code_mem[addr];
            len_rd_reg  <= len_mem[addr];
            len_ok_reg  <= len_valid_reg[addr];
        end
    end

    // per-entry valid bits, an unloaded symbol has length zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_valid_reg <= '0;
        end
        else if (ctrl.mem_write)
        begin
            len_valid_reg[addr] <= 1'b1;
        end
    end

    // mask, reverse and align the code behind the pending bits
    always_comb
    begin
        len_eff     = len_ok_reg ? len_rd_reg : 5'd0;
        mask_wide   = (17'd1 << len_eff) - 17'd1;
        code_masked = code_rd_reg & mask_wide[15:0];
        for (int i = 0; i < 16; i++)
        begin
            code_rev[15 - i] = code_masked[i];
        end
        used_bits = TOP_BIT - bit_pos_reg;
        acc       = {pending_byte_reg, 16'h0000} | ({code_rev, 8'h00} >> used_bits);
        total     = {2'b00, used_bits} + len_eff;
    end

    // next pending state
    always_comb
    begin
        pending_byte_next  = pending_byte_reg;
        bit_pos_next       = bit_pos_reg;
        pending_valid_next = pending_valid_reg;
        if (ctrl.flush)
        begin
            pending_byte_next  = 8'h00;
            bit_pos_next       = TOP_BIT;
            pending_valid_next = 1'b0;
        end
        else if (ctrl.pack)
        begin
            case (total[4:3])
                2'd0:    pending_byte_next = acc[23:16];
                2'd1:    pending_byte_next = acc[15:8];
                default: pending_byte_next = acc[7:0];
            endcase
            bit_pos_next       = TOP_BIT - total[2:0];
            pending_valid_next = (total[2:0] != 3'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_byte_reg  <= 8'h00;
            bit_pos_reg       <= TOP_BIT;
            pending_valid_reg <= 1'b0;
        end
        else
        begin
            pending_byte_reg  <= pending_byte_next;
            bit_pos_reg       <= bit_pos_next;
            pending_valid_reg <= pending_valid_next;
        end
    end

    // result bytes
    always_ff @(posedge clk)
    begin
        if (ctrl.flush)
        begin
            byte0_reg <= pending_byte_reg;
        end
        else if (ctrl.pack)
        begin
            byte0_reg <= acc[23:16];
            byte1_reg <= acc[15:8];
        end
    end

    assign out_byte = ctrl.out_sel ? byte1_reg : byte0_reg;

endmodule

// ----- rtl/core/hbp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_ctrl
// Sequencer for the huffman bit packer: accept, lookup, pack, emit bytes.
// ----------------------------------------------------------------------------
module hbp_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           in_cmd,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_last,
    input  hbp_pkg::hbp_status_t status,
    output hbp_pkg::hbp_ctrl_t   ctrl
);
    import hbp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SEND0,
        ST_SEND1
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] count_reg, count_next;
    logic       out_valid_reg, out_valid_next;
    logic       last_reg, last_next;
    logic       sel_reg, sel_next;

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign out_last     = last_reg;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        last_next      = last_reg;
        sel_next       = sel_reg;
        ctrl.mem_write = 1'b0;
        ctrl.mem_read  = 1'b0;
        ctrl.pack      = 1'b0;
        ctrl.flush     = 1'b0;
        ctrl.out_sel   = sel_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_cmd)
                        CMD_LOAD:
                        begin
                            ctrl.mem_write = status.sym_in_range;
                        end
                        CMD_ENCODE:
                        begin
                            if (status.sym_in_range)
                            begin
                                ctrl.mem_read = 1'b1;
                                state_next    = ST_LOOK;
                            end
                        end
                        CMD_FLUSH:
                        begin
                            if (status.pending_valid)
                            begin
                                ctrl.flush     = 1'b1;
                                count_next     = 2'd1;
                                out_valid_next = 1'b1;
                                last_next      = 1'b1;
                                sel_next       = 1'b0;
                                state_next     = ST_SEND0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_LOOK:
            begin
                ctrl.pack  = 1'b1;
                count_next = status.byte_count;
                sel_next   = 1'b0;
                if (status.byte_count == 2'd0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    last_next      = (status.byte_count == 2'd1);
                    state_next     = ST_SEND0;
                end
            end
            ST_SEND0:
            begin
                if (out_ready)
                begin
                    if (count_reg == 2'd2)
                    begin
                        sel_next   = 1'b1;
                        last_next  = 1'b1;
                        state_next = ST_SEND1;
                    end
                    else
                    begin
                        out_valid_next = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
            end
            ST_SEND1:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
            sel_reg       <= sel_next;
        end
    end

endmodule

// ----- rtl/core/huffman_bit_packer_top.sv -----
`timescale 1ns / 1ps
// An encode passes through the table read and the pack state before its first byte shows;
// a flush shows its byte in the cycle after the input beat. Loads and items that give no
// byte leave the block idle, though an in-range encode with no byte passes the pack state.
// One item at a time: the next beat is taken once the item's last byte is taken.
// Reset: asynchronous, active low; clears the length valid bits and the pending byte at once.
// ----------------------------------------------------------------------------
// huffman_bit_packer_top
// Huffman code table with an MSB-first byte packer for encoded symbols.
// ----------------------------------------------------------------------------
module huffman_bit_packer_top #(
    parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOLS      = hbp_pkg::SYMBOLS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  hbp_pkg::hbp_in_t  in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output hbp_pkg::hbp_out_t out_item
);
    import hbp_pkg::*;

    hbp_ctrl_t   ctrl;
    hbp_status_t status;
    logic [7:0]  out_byte;
    logic        out_last;

    // sequencer
    hbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_cmd    (in_item.cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_last  (out_last),
        .status    (status),
        .ctrl      (ctrl)
    );

    // tables and packing
    hbp_datapath #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOLS      (SYMBOLS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .ctrl     (ctrl),
        .status   (status),
        .out_byte (out_byte)
    );

    // output beat
    assign out_item = {out_byte, out_last};

    // no input beat while a result beat is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while output beat pending");

    // a table load never produces a beat
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_item.cmd == CMD_LOAD) |=> !out_valid)
        else $error("load produced an output beat");

    // after the final beat the block is idle again
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_item.last) |=> (!out_valid && in_ready))
        else $error("block not idle after final beat");

    // a flush with pending bits yields a single final beat
    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_item.cmd == CMD_FLUSH && status.pending_valid)
        |=> (out_valid && out_item.last))
        else $error("flush did not give a final beat");

endmodule

// ----- verif/hbp_packer_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbp_packer_checker
// Watches both channels of the huffman bit packer. It keeps its own copy of the
// code and length tables and of the pending byte, works out the bytes that
// every accepted input beat must produce, and compares each output beat, field
// by field, with the oldest byte still owed.
// ----------------------------------------------------------------------------
module hbp_packer_checker #(
    parameter int MAX_CODE_LEN = hbp_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOLS      = hbp_pkg::SYMBOLS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  hbp_pkg::hbp_in_t  in_item,
    input  logic              out_valid,
    input  logic              out_ready,
    input  hbp_pkg::hbp_out_t out_item,
    output int                errors,
    output int                owed,
    output int                bytes_seen,
    output int                double_bytes
);
    import hbp_pkg::*;

    // stored length is clipped to the configured maximum and to the code word width
    localparam int LEN_CAP = (MAX_CODE_LEN < CODE_BITS) ? MAX_CODE_LEN : CODE_BITS;

    logic [15:0] code_tbl [SYMBOLS];
    logic [4:0]  len_tbl  [SYMBOLS];
    logic [7:0]  pend_byte;
    logic [2:0]  bit_pos;
    logic        pend_valid;
    hbp_out_t    byte_queue [$];

    // one line per mismatch
    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    // push a completed byte onto the queue of bytes owed
    task automatic emit_byte(input logic [7:0] value);
        hbp_out_t r;
        r.out_byte = value;
        r.last     = 1'b0;
        byte_queue.push_back(r);
        pend_byte  = '0;
        bit_pos    = TOP_BIT;
        pend_valid = 1'b0;
    endtask

    // advance the packer state by one input beat
    task automatic pack_item(input hbp_in_t b);
        logic [15:0] code;
        int          len;
        int          made;
        int          start;
        hbp_out_t    tail;
        start = byte_queue.size();
        case (b.cmd)
            CMD_LOAD:
                if (int'(b.symbol) < SYMBOLS)
                begin
                    code_tbl[b.symbol] = b.code_word;
                    len_tbl[b.symbol]  = (int'(b.code_length) > LEN_CAP) ?
                                         5'(LEN_CAP) : b.code_length;
                end
            CMD_ENCODE:
                if (int'(b.symbol) < SYMBOLS)
                begin
                    code = code_tbl[b.symbol];
                    len  = int'(len_tbl[b.symbol]);
                    for (int k = 0; k < len; k++)
                    begin
                        if (code[k])
                            pend_byte[bit_pos] = 1'b1;
                        pend_valid = 1'b1;
                        if (bit_pos == 3'd0)
                            emit_byte(pend_byte);
                        else
                            bit_pos = bit_pos - 3'd1;
                    end
                end
            CMD_FLUSH:
                if (pend_valid)
                    emit_byte(pend_byte);
            default:
                ;
        endcase
        // final byte of the beat carries last
        made = byte_queue.size() - start;
        if (made > 0)
        begin
            tail      = byte_queue[byte_queue.size() - 1];
            tail.last = 1'b1;
            byte_queue[byte_queue.size() - 1] = tail;
        end
        if (made == 2)
            double_bytes++;
    endtask

    // predict on input beats, check output beats
    always @(posedge clk or negedge rst_n)
    begin
        hbp_out_t want;
        if (!rst_n)
        begin
            for (int s = 0; s < SYMBOLS; s++)
            begin
                code_tbl[s] = '0;
                len_tbl[s]  = '0;
            end
            pend_byte    = '0;
            bit_pos      = TOP_BIT;
            pend_valid   = 1'b0;
            byte_queue.delete();
            errors       = 0;
            bytes_seen   = 0;
            double_bytes = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                pack_item(in_item);
            if (out_valid && out_ready)
            begin
                bytes_seen++;
                if (byte_queue.size() == 0)
                    report($sformatf("unexpected byte %02h last %0b",
                                     out_item.out_byte, out_item.last));
                else
                begin
                    want = byte_queue.pop_front();
                    if (out_item.out_byte !== want.out_byte)
                        report($sformatf("byte %0d: out_byte %02h, want %02h",
                                         bytes_seen, out_item.out_byte, want.out_byte));
                    if (out_item.last !== want.last)
                        report($sformatf("byte %0d: last %0b, want %0b",
                                         bytes_seen, out_item.last, want.last));
                end
            end
        end
        owed = byte_queue.size();
    end

endmodule

// ----- verif/huffman_bit_packer_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_bit_packer_top_test
// Drives the huffman bit packer with a directed opening (table extremes,
// length saturation, unloaded symbols, empty and partial flushes, two-byte
// encodes) and then about 950 random load, encode and flush beats, with random
// gaps on the input and random stalls on the output. The checker beside the
// block does the prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
module huffman_bit_packer_top_test;
    import hbp_pkg::*;

    localparam int RANDOM_ITEMS = 950;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    hbp_in_t  in_item   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    hbp_out_t out_item;

    int   errors;
    int   owed;
    int   bytes_seen;
    int   double_bytes;
    int   quiet      = 0;
    int   stall_left = 0;
    logic steady     = 1'b0;
    int   n_load     = 0;
    int   n_encode   = 0;
    int   n_flush    = 0;
    int   n_unused   = 0;
    logic [7:0] loaded_syms [$];

    huffman_bit_packer_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    hbp_packer_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_item      (in_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_item     (out_item),
        .errors       (errors),
        .owed         (owed),
        .bytes_seen   (bytes_seen),
        .double_bytes (double_bytes)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // idle length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 92)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic hbp_in_t mk(input logic [1:0] cmd, input logic [7:0] sym,
                                   input logic [15:0] word, input logic [4:0] len);
        hbp_in_t b;
        b.cmd         = cmd;
        b.symbol      = sym;
        b.code_word   = word;
        b.code_length = len;
        return b;
    endfunction

    // random beat: mostly encodes of loaded symbols, some loads and flushes
    function automatic hbp_in_t random_item();
        hbp_in_t b;
        int      r;
        b = mk(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom),
               5'($urandom_range(0, 31)));
        r = $urandom_range(0, 99);
        if (r < 18)
        begin
            b.cmd = CMD_LOAD;
            if ($urandom_range(0, 9) != 0)
                b.code_length = 5'($urandom_range(0, 16));
        end
        else if (r < 85)
        begin
            b.cmd = CMD_ENCODE;
            if (loaded_syms.size() != 0 && $urandom_range(0, 99) < 85)
                b.symbol = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        end
        else if (r < 97)
            b.cmd = CMD_FLUSH;
        else
            b.cmd = 2'd3;
        return b;
    endfunction

    // one input beat, after an optional idle gap
    task automatic send_beat(input hbp_in_t b);
        int gap;
        gap = (steady || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        case (b.cmd)
            CMD_LOAD:
            begin
                n_load++;
                loaded_syms.push_back(b.symbol);
                if (loaded_syms.size() > 24)
                    void'(loaded_syms.pop_front());
            end
            CMD_ENCODE: n_encode++;
            CMD_FLUSH:  n_flush++;
            default:    n_unused++;
        endcase
    endtask

    // output stalls
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!steady && $urandom_range(0, 99) < 25)
        begin
            out_ready  <= 1'b0;
            stall_left <= pick_gap() - 1;
        end
        else
            out_ready <= 1'b1;
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("huffman_bit_packer_top verification failed");
            $finish;
        end
    end

    initial
    begin
        hbp_in_t opening [$];
        hbp_in_t b;
        int      sent;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening
        opening.push_back(mk(CMD_ENCODE, 8'd200, 16'h1234, 5'd9));   // unloaded symbol
        opening.push_back(mk(CMD_FLUSH,  8'd0,   16'h0000, 5'd0));   // nothing pending
        opening.push_back(mk(2'd3,       8'hFF,  16'hFFFF, 5'd31));  // unused command
        opening.push_back(mk(CMD_LOAD,   8'd0,   16'hFFFF, 5'd16));
        opening.push_back(mk(CMD_LOAD,   8'd255, 16'h0000, 5'd31));  // saturates
        opening.push_back(mk(CMD_LOAD,   8'd1,   16'hAAAA, 5'd0));   // zero length
        opening.push_back(mk(CMD_LOAD,   8'd2,   16'h0001, 5'd1));
        opening.push_back(mk(CMD_LOAD,   8'd3,   16'h0055, 5'd7));
        opening.push_back(mk(CMD_LOAD,   8'd4,   16'h00A5, 5'd8));
        opening.push_back(mk(CMD_LOAD,   8'd5,   16'h8001, 5'd17));  // saturates
        opening.push_back(mk(CMD_ENCODE, 8'd0,   16'h0000, 5'd0));   // two bytes
        opening.push_back(mk(CMD_ENCODE, 8'd255, 16'h0000, 5'd0));   // two zero bytes
        opening.push_back(mk(CMD_ENCODE, 8'd1,   16'h0000, 5'd0));   // loaded, no bits
        opening.push_back(mk(CMD_ENCODE, 8'd2,   16'h0000, 5'd0));
        opening.push_back(mk(CMD_FLUSH,  8'd0,   16'h0000, 5'd0));   // one bit pending
        opening.push_back(mk(CMD_ENCODE, 8'd3,   16'h0000, 5'd0));
        opening.push_back(mk(CMD_ENCODE, 8'd2,   16'h0000, 5'd0));   // completes a byte
        opening.push_back(mk(CMD_ENCODE, 8'd5,   16'h0000, 5'd0));
        opening.push_back(mk(CMD_ENCODE, 8'd3,   16'h0000, 5'd0));
        opening.push_back(mk(CMD_ENCODE, 8'd4,   16'h0000, 5'd0));
        opening.push_back(mk(CMD_ENCODE, 8'd0,   16'h0000, 5'd0));   // straddles bytes
        opening.push_back(mk(CMD_FLUSH,  8'd0,   16'h0000, 5'd0));
        opening.push_back(mk(CMD_FLUSH,  8'd0,   16'h0000, 5'd0));
        foreach (opening[i])
            send_beat(opening[i]);

        // random part in blocks, some blocks with no idling at all
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            steady <= ($urandom_range(0, 3) == 0);
            repeat (50)
            begin
                b = random_item();
                send_beat(b);
                if (b.cmd != 2'd3)
                    sent++;
            end
        end
        in_valid <= 1'b0;
        steady   <= 1'b0;

        // drain
        @(negedge clk);
        while (owed != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d loads, %0d encodes, %0d flushes, %0d unused commands",
                 n_load, n_encode, n_flush, n_unused);
        $display("run: %0d bytes checked, %0d encodes gave two bytes, %0d mismatches",
                 bytes_seen, double_bytes, errors);
        if (errors == 0 && owed == 0)
            $display("huffman_bit_packer_top verification clean");
        else
            $display("huffman_bit_packer_top verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/hbp_pkg.sv
rtl/core/hbp_datapath.sv
rtl/core/hbp_ctrl.sv
rtl/core/huffman_bit_packer_top.sv
verif/hbp_packer_checker.sv
verif/huffman_bit_packer_top_test.sv
